// ===== rtl/set_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_pkg
// Shared constants for the sorted extent table.
// ----------------------------------------------------------------------------
package set_pkg;

    localparam int FIELD_W = 32;
    localparam int COUNT_W = 7;
    localparam int TOTAL_W = 33;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_TRUNC = 1'b1;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

endpackage

// ===== rtl/set_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_req_if
// Request channel: one operation beat per handshake.
// ----------------------------------------------------------------------------
interface set_req_if;
    import set_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [FIELD_W-1:0] first_block;
    logic [FIELD_W-1:0] last_block;

    modport source (output valid, action, first_block, last_block, input ready);
    modport sink   (input valid, action, first_block, last_block, output ready);
endinterface

// ===== rtl/set_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_rsp_if
// Response channel: one result beat per operation.
// ----------------------------------------------------------------------------
interface set_rsp_if;
    import set_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic [COUNT_W-1:0] extent_count;
    logic [TOTAL_W-1:0] total_blocks;

    modport source (output valid, status, extent_count, total_blocks, input ready);
    modport sink   (input valid, status, extent_count, total_blocks, output ready);
endinterface

// ===== rtl/set_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_mem
// Extent storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module set_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/set_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_acc
// Saturating block-count accumulator, one extent per enable.
// ----------------------------------------------------------------------------
module set_acc #(
    parameter int BLOCK_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_en,
    input  logic [BLOCK_BITS-1:0]         i_start,
    input  logic [BLOCK_BITS-1:0]         i_end,
    output logic [set_pkg::TOTAL_W-1:0]   o_total
);
    import set_pkg::*;

    localparam int SW = ((BLOCK_BITS > TOTAL_W) ? BLOCK_BITS : TOTAL_W) + 2;

    logic [TOTAL_W-1:0]    r_acc;
    logic                  r_sat;
    logic [BLOCK_BITS-1:0] w_d;
    logic [SW-1:0]         w_dd;
    logic [SW-1:0]         w_sum;
    logic [SW-1:0]         w_max;
    logic                  w_ovf;

    assign w_d   = i_end - i_start;
    assign w_dd  = SW'(w_d);
    assign w_max = SW'(TOTAL_MAX);
    assign w_sum = SW'(r_acc) + w_dd + SW'(1);
    assign w_ovf = (w_dd >= w_max) || (w_sum > w_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (i_en && !(i_end < i_start)) begin
            if (r_sat || w_ovf) begin
                r_sat <= 1'b1;
            end else begin
                r_acc <= w_sum[TOTAL_W-1:0];
            end
        end
    end

    assign o_total = r_sat ? TOTAL_MAX : r_acc;
endmodule

// ===== rtl/sorted_extent_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_extent_table
// Sorted extent list with coalescing adds and truncation.
// ----------------------------------------------------------------------------
// One operation at a time; the request side is ready only when idle. Extents
// sit in a single-port-write memory and each operation walks it: a search
// over the extents below the new start, a shift for an insert or a coalesce,
// then a pass that clips on truncate and sums block counts. The result sits
// in an output register; the next request is taken while it waits.
module sorted_extent_table #(
    parameter int MAX_EXTENTS = 64,
    parameter int BLOCK_BITS  = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    set_req_if.sink   i_req,
    set_rsp_if.source o_rsp
);
    import set_pkg::*;

    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int BB = BLOCK_BITS;
    localparam int EW = 2 * BB;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN_RD = 4'd1;
    localparam logic [3:0] S_SCAN_CK = 4'd2;
    localparam logic [3:0] S_DECIDE  = 4'd3;
    localparam logic [3:0] S_MV_RD   = 4'd4;
    localparam logic [3:0] S_MV_WR   = 4'd5;
    localparam logic [3:0] S_PUT     = 4'd6;
    localparam logic [3:0] S_SUM_RD  = 4'd7;
    localparam logic [3:0] S_SUM_CK  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]         r_st, n_st;
    logic               r_act, n_act;
    logic [BB-1:0]      r_first, n_first;
    logic [BB-1:0]      r_last, n_last;
    logic [CW-1:0]      r_held, n_held;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_n, n_n;
    logic [EW-1:0]      r_prev, n_prev;
    logic [EW-1:0]      r_next, n_next;
    logic               r_has_next, n_has_next;
    logic               r_up, n_up;
    logic               r_status, n_status;
    logic               r_ov, n_ov;
    logic               r_o_status, n_o_status;
    logic [COUNT_W-1:0] r_o_count, n_o_count;
    logic [TOTAL_W-1:0] r_o_total, n_o_total;

    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic [EW-1:0]      w_wdata;
    logic [IW-1:0]      w_raddr;
    logic [EW-1:0]      w_rdata;

    logic               w_clear;
    logic               w_acc_en;
    logic [BB-1:0]      w_s;
    logic [BB-1:0]      w_e;
    logic [BB-1:0]      w_e_clip;
    logic [TOTAL_W-1:0] w_total;

    logic [BB+FIELD_W-1:0] w_first_x;
    logic [BB+FIELD_W-1:0] w_last_x;
    logic [CW+COUNT_W-1:0] w_count_x;

    assign w_first_x = {{BB{1'b0}}, i_req.first_block};
    assign w_last_x  = {{BB{1'b0}}, i_req.last_block};

    assign w_s      = w_rdata[EW-1:BB];
    assign w_e      = w_rdata[BB-1:0];
    assign w_e_clip = (r_act == ACT_TRUNC && w_e >= r_first) ? (r_first - BB'(1)) : w_e;

    set_mem #(
        .DEPTH (MAX_EXTENTS),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    set_acc #(
        .BLOCK_BITS (BB)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_en    (w_acc_en),
        .i_start (w_s),
        .i_end   (w_e_clip),
        .o_total (w_total)
    );

    assign i_req.ready        = (r_st == S_IDLE);
    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.extent_count = r_o_count;
    assign o_rsp.total_blocks = r_o_total;

    always_comb begin
        n_st       = r_st;
        n_act      = r_act;
        n_first    = r_first;
        n_last     = r_last;
        n_held     = r_held;
        n_idx      = r_idx;
        n_n        = r_n;
        n_prev     = r_prev;
        n_next     = r_next;
        n_has_next = r_has_next;
        n_up       = r_up;
        n_status   = r_status;
        n_ov       = r_ov;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;
        n_o_total  = r_o_total;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = '0;
        w_raddr    = '0;
        w_clear    = 1'b0;
        w_acc_en   = 1'b0;
        w_count_x  = {{COUNT_W{1'b0}}, r_held};

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        case (r_st)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_act      = i_req.action;
                    n_first    = w_first_x[BB-1:0];
                    n_last     = w_last_x[BB-1:0];
                    n_idx      = '0;
                    n_has_next = 1'b0;
                    n_status   = STAT_OK;
                    n_st       = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (r_idx == r_held) begin
                    n_n  = r_idx;
                    n_st = S_DECIDE;
                end else begin
                    w_raddr = r_idx[IW-1:0];
                    n_st    = S_SCAN_CK;
                end
            end
            S_SCAN_CK: begin
                if (w_s < r_first) begin
                    n_prev = w_rdata;
                    n_idx  = r_idx + CW'(1);
                    n_st   = S_SCAN_RD;
                end else begin
                    n_n        = r_idx;
                    n_next     = w_rdata;
                    n_has_next = 1'b1;
                    n_st       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_idx   = '0;
                w_clear = 1'b1;
                n_st    = S_SUM_RD;
                if (r_act == ACT_TRUNC) begin
                    n_held = r_n;
                end else if (r_n != '0 && r_prev[BB-1:0] == (r_first - BB'(1))) begin
                    w_we    = 1'b1;
                    w_waddr = IW'(r_n - CW'(1));
                    if (r_has_next && (r_last + BB'(1)) == r_next[EW-1:BB]) begin
                        w_wdata = {r_prev[EW-1:BB], r_next[BB-1:0]};
                        n_idx   = r_n + CW'(1);
                        n_up    = 1'b0;
                        w_clear = 1'b0;
                        n_st    = S_MV_RD;
                    end else begin
                        w_wdata = {r_prev[EW-1:BB], r_last};
                    end
                end else if (r_held >= CW'(MAX_EXTENTS)) begin
                    n_status = STAT_FULL;
                end else begin
                    n_idx   = r_held;
                    n_up    = 1'b1;
                    w_clear = 1'b0;
                    n_st    = S_MV_RD;
                end
            end
            S_MV_RD: begin
                if (r_up) begin
                    if (r_idx == r_n) begin
                        n_st = S_PUT;
                    end else begin
                        w_raddr = IW'(r_idx - CW'(1));
                        n_st    = S_MV_WR;
                    end
                end else begin
                    if (r_idx >= r_held) begin
                        n_held  = r_held - CW'(1);
                        n_idx   = '0;
                        w_clear = 1'b1;
                        n_st    = S_SUM_RD;
                    end else begin
                        w_raddr = r_idx[IW-1:0];
                        n_st    = S_MV_WR;
                    end
                end
            end
            S_MV_WR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                if (r_up) begin
                    w_waddr = r_idx[IW-1:0];
                    n_idx   = r_idx - CW'(1);
                end else begin
                    w_waddr = IW'(r_idx - CW'(1));
                    n_idx   = r_idx + CW'(1);
                end
                n_st = S_MV_RD;
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_n[IW-1:0];
                w_wdata = {r_first, r_last};
                n_held  = r_held + CW'(1);
                n_idx   = '0;
                w_clear = 1'b1;
                n_st    = S_SUM_RD;
            end
            S_SUM_RD: begin
                if (r_idx == r_held) begin
                    n_st = S_DONE;
                end else begin
                    w_raddr = r_idx[IW-1:0];
                    n_st    = S_SUM_CK;
                end
            end
            S_SUM_CK: begin
                w_acc_en = 1'b1;
                if (w_e_clip != w_e) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IW-1:0];
                    w_wdata = {w_s, w_e_clip};
                end
                n_idx = r_idx + CW'(1);
                n_st  = S_SUM_RD;
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_count  = w_count_x[COUNT_W-1:0];
                    n_o_total  = w_total;
                    n_st       = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_held <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_held <= n_held;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_first    <= n_first;
        r_last     <= n_last;
        r_idx      <= n_idx;
        r_n        <= n_n;
        r_prev     <= n_prev;
        r_next     <= n_next;
        r_has_next <= n_has_next;
        r_up       <= n_up;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_total  <= n_o_total;
    end
endmodule

// ===== dv/sorted_extent_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_extent_table_test
// Drives add and truncate operations into the sorted extent table with random
// gaps on both channels and checks each response beat against a behavioral
// model of the table held in the bench. A directed table of cases comes first,
// then a table-full run, then random coalescing sequences and truncations.
// ----------------------------------------------------------------------------
module sorted_extent_table_test;
    import set_pkg::*;

    localparam int DEPTH     = 64;
    localparam int CYCLE_CAP = 4000000;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] extent_count;
        logic [TOTAL_W-1:0] total_blocks;
    } table_result_t;

    typedef struct {
        logic               action;
        logic [FIELD_W-1:0] first_block;
        logic [FIELD_W-1:0] last_block;
        bit                 typed;
        table_result_t      result;
    } op_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    set_req_if req_ch ();
    set_rsp_if rsp_ch ();

    sorted_extent_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #10 i_clk = ~i_clk;

    logic [FIELD_W-1:0] tbl_start [DEPTH];
    logic [FIELD_W-1:0] tbl_end   [DEPTH];
    int                 tbl_held;
    table_result_t      pending_results[$];
    int                 mismatches;
    longint             cycles;
    op_row_t            directed[$];

    function automatic logic [TOTAL_W-1:0] table_sum();
        logic [TOTAL_W:0] acc;
        acc = '0;
        for (int i = 0; i < tbl_held; i++) begin
            if (tbl_end[i] >= tbl_start[i]) begin
                acc = acc + (tbl_end[i] - tbl_start[i]) + 1;
                if (acc > TOTAL_MAX) return TOTAL_MAX;
            end
        end
        return acc[TOTAL_W-1:0];
    endfunction

    function automatic table_result_t apply_op(logic act, logic [FIELD_W-1:0] fb,
                                               logic [FIELD_W-1:0] lb);
        table_result_t r;
        int n;
        int c;
        r.status = STAT_OK;
        n = 0;
        while (n < tbl_held && tbl_start[n] < fb) n++;
        if (act == ACT_ADD) begin
            c = n - 1;
            if (n > 0 && tbl_end[c] == fb - 1'b1) begin
                tbl_end[c] = lb;
                if (c + 1 < tbl_held && lb + 1'b1 == tbl_start[c + 1]) begin
                    tbl_end[c] = tbl_end[c + 1];
                    for (int i = c + 1; i + 1 < tbl_held; i++) begin
                        tbl_start[i] = tbl_start[i + 1];
                        tbl_end[i]   = tbl_end[i + 1];
                    end
                    tbl_held--;
                end
            end else if (tbl_held >= DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                for (int i = tbl_held; i > n; i--) begin
                    tbl_start[i] = tbl_start[i - 1];
                    tbl_end[i]   = tbl_end[i - 1];
                end
                tbl_start[n] = fb;
                tbl_end[n]   = lb;
                tbl_held++;
            end
        end else begin
            tbl_held = n;
            for (int i = 0; i < n; i++)
                if (tbl_end[i] >= fb) tbl_end[i] = fb - 1'b1;
        end
        r.extent_count = COUNT_W'(tbl_held);
        r.total_blocks = table_sum();
        return r;
    endfunction

    function automatic int idle_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_op(logic act, logic [FIELD_W-1:0] fb, logic [FIELD_W-1:0] lb,
                           bit typed, table_result_t typed_res);
        table_result_t r;
        int gap;
        r = apply_op(act, fb, lb);
        if (typed && r !== typed_res) begin
            mismatches++;
            if (mismatches <= 10)
                $display("row table entry disagrees: typed %h model %h", typed_res, r);
        end
        pending_results.push_back(r);
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.first_block <= fb;
        req_ch.last_block  <= lb;
        do @(posedge i_clk); while (!req_ch.ready);
        gap = idle_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic op_row_t row(logic act, logic [FIELD_W-1:0] fb,
                                    logic [FIELD_W-1:0] lb, bit typed = 0,
                                    logic st = STAT_OK, int cnt = 0, longint tot = 0);
        op_row_t r;
        r.action = act;
        r.first_block = fb;
        r.last_block = lb;
        r.typed = typed;
        r.result = '{st, COUNT_W'(cnt), TOTAL_W'(tot)};
        return r;
    endfunction

    // response side: random backpressure, compare against oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected response beat");
                end else begin
                    table_result_t e;
                    e = pending_results.pop_front();
                    if (rsp_ch.status !== e.status || rsp_ch.extent_count !== e.extent_count
                        || rsp_ch.total_blocks !== e.total_blocks) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response mismatch: exp st=%0b cnt=%0d tot=%0d got st=%0b cnt=%0d tot=%0d",
                                     e.status, e.extent_count, e.total_blocks, rsp_ch.status,
                                     rsp_ch.extent_count, rsp_ch.total_blocks);
                    end
                end
            end
            begin
                int k;
                k = $urandom_range(0, 99);
                rsp_ch.ready <= (k != 0) && ((cycles % 2000 < 300) || (k < 70));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] fb;
        logic [FIELD_W-1:0] lb;
        int sent;
        int k;
        mismatches = 0;
        cycles = 0;
        tbl_held = 0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_ADD;
        req_ch.first_block = '0;
        req_ch.last_block = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, coalescing both ways, equal starts, reversed, clear
        directed.push_back(row(ACT_TRUNC, 32'd0, 32'hFFFF_FFFF, 1, STAT_OK, 0, 0));
        directed.push_back(row(ACT_ADD, 32'd0, 32'hFFFF_FFFF, 1, STAT_OK, 1, 64'h1_0000_0000));
        directed.push_back(row(ACT_TRUNC, 32'd0, 32'd0, 1, STAT_OK, 0, 0));
        directed.push_back(row(ACT_ADD, 32'd10, 32'd19, 1, STAT_OK, 1, 10));
        directed.push_back(row(ACT_ADD, 32'd30, 32'd39, 1, STAT_OK, 2, 20));
        directed.push_back(row(ACT_ADD, 32'd20, 32'd29));
        directed.push_back(row(ACT_ADD, 32'd40, 32'd40));
        directed.push_back(row(ACT_ADD, 32'd5, 32'd2));
        directed.push_back(row(ACT_ADD, 32'd5, 32'd7));
        directed.push_back(row(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(row(ACT_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFE));
        directed.push_back(row(ACT_ADD, 32'h8000_0000, 32'hFFFF_FFFF));
        directed.push_back(row(ACT_TRUNC, 32'd25, 32'd0));
        directed.push_back(row(ACT_TRUNC, 32'hFFFF_FFFF, 32'd0));
        directed.push_back(row(ACT_ADD, 32'h5555_5555, 32'hAAAA_AAAA));
        directed.push_back(row(ACT_TRUNC, 32'h6000_0000, 32'd0));
        directed.push_back(row(ACT_TRUNC, 32'd0, 32'd0, 1, STAT_OK, 0, 0));
        foreach (directed[i])
            send_op(directed[i].action, directed[i].first_block, directed[i].last_block,
                    directed[i].typed, directed[i].result);

        // fill to capacity, hit full, then extend while full
        for (int i = 0; i < DEPTH; i++)
            send_op(ACT_ADD, 32'(i * 4), 32'(i * 4 + 1), 0, '0);
        send_op(ACT_ADD, 32'h1000, 32'h1001, 1, '{STAT_FULL, 7'd64, 33'd128});
        send_op(ACT_ADD, 32'd2, 32'd2, 0, '0);
        send_op(ACT_ADD, 32'd3, 32'd3, 0, '0);
        send_op(ACT_TRUNC, 32'd0, 32'd0, 1, '{STAT_OK, 7'd0, 33'd0});

        sent = 0;
        while (sent < 465) begin
            k = $urandom_range(0, 99);
            base = (k < 20) ? $urandom() : $urandom_range(0, 2000);
            if (k < 8) begin
                send_op(ACT_TRUNC, (k < 2) ? 32'd0 : base, $urandom(), 0, '0);
                sent++;
            end else if (k < 14) begin
                fb = $urandom();
                lb = $urandom();
                send_op(ACT_ADD, fb, lb, 0, '0);
                sent++;
            end else begin
                // run of adjacent pieces, shuffled so coalescing kicks in
                int pieces;
                int order[$];
                pieces = $urandom_range(2, 6);
                for (int p = 0; p < pieces; p++) order.push_back(p);
                order.shuffle();
                foreach (order[p]) begin
                    fb = base + order[p] * 8;
                    lb = fb + 7;
                    send_op(ACT_ADD, fb, lb, 0, '0);
                    sent++;
                end
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/set_pkg.sv
rtl/set_req_if.sv
rtl/set_rsp_if.sv
rtl/set_mem.sv
rtl/set_acc.sv
rtl/sorted_extent_table.sv
dv/sorted_extent_table_test.sv
